// ===== rtl/nco_cfs_pkg.sv =====
// Package for the NCO complex frequency shifter: shared widths and the
// quarter-wave sine table generator used by the ROM at elaboration.
// No dependencies.
package nco_cfs_pkg;

  // Default module parameters
  localparam int unsigned SAMPLE_BITS_DEF     = 16;
  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned TABLE_ADDR_BITS_DEF = 10;

  // Width of the phase_step register
  localparam int unsigned STEP_BITS = 32;

  // Table entries are unsigned Q0.15 magnitudes; signed coefficients add a bit
  localparam int unsigned COEF_FRAC = 15;
  localparam int unsigned COEF_BITS = COEF_FRAC + 1;
  localparam int unsigned COEF_MAX  = (1 << COEF_FRAC) - 1;

  // pi/2 in Q2.30
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // sin(pi/2 * k / 2^addr_bits) by an integer Taylor series in Q2.30 up to
  // the x^13 term, rounded half up to unsigned Q0.15 and clamped to [0, COEF_MAX].
  function automatic logic [COEF_FRAC-1:0] sine_q15(int unsigned k,
                                                    int unsigned addr_bits);
    logic [63:0]    x;
    logic [63:0]    x2;
    logic [63:0]    term;
    logic [63:0]    prod;
    logic signed [63:0] sum;
    x    = (64'(k) * PI_HALF_Q30) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 6; n++) begin
      prod = (term * x2) >> 30;
      // divide by (2n)(2n+1)
      case (n)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        default: term = prod / 64'd156;
      endcase
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'(COEF_MAX)) begin
      sum = 64'(COEF_MAX);
    end
    return sum[COEF_FRAC-1:0];
  endfunction

endpackage

// ===== rtl/nco_cfs_rom.sv =====
// Quarter-wave sine ROM with two registered read ports.
// Depends on nco_cfs_pkg for the table generator.
module nco_cfs_rom #(
  parameter int unsigned TABLE_ADDR_BITS = nco_cfs_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [TABLE_ADDR_BITS:0]          addr_a_i,
  input  logic [TABLE_ADDR_BITS:0]          addr_b_i,
  output logic [nco_cfs_pkg::COEF_FRAC-1:0] data_a_o,
  output logic [nco_cfs_pkg::COEF_FRAC-1:0] data_b_o
);
  import nco_cfs_pkg::*;

  localparam int unsigned TABLE_LEN = 1 << TABLE_ADDR_BITS;

  logic [COEF_FRAC-1:0] rom [TABLE_LEN+1];

  // constant contents: sin over one quarter wave, both end points included
  for (genvar g = 0; g <= TABLE_LEN; g++) begin : g_rom
    assign rom[g] = sine_q15(g, TABLE_ADDR_BITS);
  end

  // registered reads, held while the pipeline stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_o <= rom[addr_a_i];
      data_b_o <= rom[addr_b_i];
    end
  end

endmodule

// ===== rtl/nco_complex_frequency_shifter.sv =====
// NCO complex frequency shifter (mixer). Top level.
// Depends on nco_cfs_pkg and nco_cfs_rom.
//
// Rotates each complex Q1.15 sample by the phase of a numerically controlled
// oscillator: i_out = I*cos - Q*sin, q_out = I*sin + Q*cos, rounded half up
// and saturated. The phase starts at zero, each sample uses the phase before
// its step is added, and a request with last_sample set returns the phase to
// zero for the next block. phase_step is in cycles per sample scaled by 2^32.
// Throughput is one sample per clock while the output is not stalled. An
// accepted request passes four registers before its result shows on the
// output: phase/table address, sine ROM read, the four 16-bit coefficient
// multipliers, and round/saturate into the output register. Backpressure
// stalls the pipeline only where a stage is full.
module nco_complex_frequency_shifter #(
  parameter int unsigned SAMPLE_BITS     = nco_cfs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned PHASE_BITS      = nco_cfs_pkg::PHASE_BITS_DEF,
  parameter int unsigned TABLE_ADDR_BITS = nco_cfs_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              phase_step_we_i,
  input  logic [nco_cfs_pkg::STEP_BITS-1:0] phase_step_i,
  // input samples
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]     i_in_i,
  input  logic signed [SAMPLE_BITS-1:0]     q_in_i,
  input  logic                              last_sample_i,
  // output samples
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     i_out_o,
  output logic signed [SAMPLE_BITS-1:0]     q_out_o,
  output logic                              last_out_o
);
  import nco_cfs_pkg::*;

  localparam int unsigned TABLE_LEN = 1 << TABLE_ADDR_BITS;
  localparam int unsigned PROD_W    = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned SUM_W     = PROD_W + 1;
  localparam int unsigned RES_W     = SUM_W - COEF_FRAC;

  localparam logic signed [SUM_W-1:0] RND    = SUM_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [RES_W-1:0] SAT_HI = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_LO = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its successor moves on
  // ---------------------------------------------------------------------------
  logic out_v_q, s3_v_q, s2_v_q, s1_v_q;
  logic out_en, s3_en, s2_en, s1_en;
  logic accept;

  assign out_en     = !out_v_q || out_ready_i;
  assign s3_en      = !s3_v_q || out_en;
  assign s2_en      = !s2_v_q || s3_en;
  assign s1_en      = !s1_v_q || s2_en;
  assign in_ready_o = s1_en;
  assign accept     = in_valid_i && s1_en;

  // ---------------------------------------------------------------------------
  // Phase step register and scaling to the accumulator width
  // ---------------------------------------------------------------------------
  logic [STEP_BITS-1:0]  phase_step_q;
  logic [PHASE_BITS-1:0] step_scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
    end else if (phase_step_we_i) begin
      phase_step_q <= phase_step_i;
    end
  end

  if (PHASE_BITS == STEP_BITS) begin : g_step_eq
    assign step_scaled = phase_step_q;
  end else if (PHASE_BITS > STEP_BITS) begin : g_step_up
    assign step_scaled = {phase_step_q, {(PHASE_BITS-STEP_BITS){1'b0}}};
  end else begin : g_step_dn
    assign step_scaled = phase_step_q[STEP_BITS-1 -: PHASE_BITS];
  end

  // ---------------------------------------------------------------------------
  // Phase accumulator: advances per accepted request, cleared after last
  // ---------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] phase_q, phase_d;

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = last_sample_i ? '0 : phase_q + step_scaled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register, quadrant and table addresses
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] s1_i_q, s1_q_q;
  logic                          s1_last_q;
  logic [1:0]                    s1_quad_q;
  logic [TABLE_ADDR_BITS:0]      s1_addr_a_q, s1_addr_b_q;
  logic [TABLE_ADDR_BITS-1:0]    k_idx;

  assign k_idx = phase_q[PHASE_BITS-3 -: TABLE_ADDR_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_i_q      <= i_in_i;
      s1_q_q      <= q_in_i;
      s1_last_q   <= last_sample_i;
      s1_quad_q   <= phase_q[PHASE_BITS-1 -: 2];
      s1_addr_a_q <= {1'b0, k_idx};
      s1_addr_b_q <= (TABLE_ADDR_BITS+1)'(TABLE_LEN) - {1'b0, k_idx};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sine ROM read (T[k] and T[N-k])
  // ---------------------------------------------------------------------------
  logic [COEF_FRAC-1:0]          s2_ta, s2_tb;
  logic signed [SAMPLE_BITS-1:0] s2_i_q, s2_q_q;
  logic                          s2_last_q;
  logic [1:0]                    s2_quad_q;

  nco_cfs_rom #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_rom (
    .clk_i   (clk_i),
    .en_i    (s2_en),
    .addr_a_i(s1_addr_a_q),
    .addr_b_i(s1_addr_b_q),
    .data_a_o(s2_ta),
    .data_b_o(s2_tb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_i_q    <= s1_i_q;
      s2_q_q    <= s1_q_q;
      s2_last_q <= s1_last_q;
      s2_quad_q <= s1_quad_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: quadrant symmetry and the four products
  // ---------------------------------------------------------------------------
  logic signed [COEF_BITS-1:0] ta_s, tb_s, sin_c, cos_c;
  logic signed [PROD_W-1:0]    s3_ic_q, s3_qs_q, s3_is_q, s3_qc_q;
  logic                        s3_last_q;

  assign ta_s = $signed({1'b0, s2_ta});
  assign tb_s = $signed({1'b0, s2_tb});

  always_comb begin
    case (s2_quad_q)
      2'd0: begin
        sin_c = ta_s;
        cos_c = tb_s;
      end
      2'd1: begin
        sin_c = tb_s;
        cos_c = -ta_s;
      end
      2'd2: begin
        sin_c = -ta_s;
        cos_c = -tb_s;
      end
      default: begin
        sin_c = -tb_s;
        cos_c = ta_s;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      s3_ic_q   <= PROD_W'(s2_i_q) * PROD_W'(cos_c);
      s3_qs_q   <= PROD_W'(s2_q_q) * PROD_W'(sin_c);
      s3_is_q   <= PROD_W'(s2_i_q) * PROD_W'(sin_c);
      s3_qc_q   <= PROD_W'(s2_q_q) * PROD_W'(cos_c);
      s3_last_q <= s2_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: sum, round half up, saturate into the output register
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0]       sum_i, sum_q;
  logic signed [RES_W-1:0]       rnd_i, rnd_q;
  logic signed [SAMPLE_BITS-1:0] sat_i, sat_q;
  logic signed [SAMPLE_BITS-1:0] i_out_q, q_out_q;
  logic                          last_out_q;

  always_comb begin
    sum_i = {s3_ic_q[PROD_W-1], s3_ic_q} - {s3_qs_q[PROD_W-1], s3_qs_q} + RND;
    sum_q = {s3_is_q[PROD_W-1], s3_is_q} + {s3_qc_q[PROD_W-1], s3_qc_q} + RND;
    rnd_i = $signed(sum_i[SUM_W-1:COEF_FRAC]);
    rnd_q = $signed(sum_q[SUM_W-1:COEF_FRAC]);

    if (rnd_i > SAT_HI) begin
      sat_i = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rnd_i < SAT_LO) begin
      sat_i = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_i = rnd_i[SAMPLE_BITS-1:0];
    end

    if (rnd_q > SAT_HI) begin
      sat_q = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rnd_q < SAT_LO) begin
      sat_q = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_q = rnd_q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      i_out_q    <= sat_i;
      q_out_q    <= sat_q;
      last_out_q <= s3_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign i_out_o     = i_out_q;
  assign q_out_o     = q_out_q;
  assign last_out_o  = last_out_q;

endmodule

// ===== rtl/nco_cfs_checker.sv =====
// Port-level checker for the NCO complex frequency shifter, with its bind.
// Depends on nco_complex_frequency_shifter (bind target) and nco_cfs_pkg.
module nco_cfs_checker #(
  parameter int unsigned SAMPLE_BITS = nco_cfs_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] i_out_o,
  input logic signed [SAMPLE_BITS-1:0] q_out_o,
  input logic                          last_out_o
);
  import nco_cfs_pkg::*;

  localparam int unsigned DEPTH = 4;

  // requests in flight: accepted inputs not yet delivered
  logic [2:0] inflight_q, inflight_d;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_fire && !out_fire) begin
      inflight_d = inflight_q + 3'd1;
    end else if (!in_fire && out_fire) begin
      inflight_d = inflight_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // a result is never shown without an accepted request behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 3'd0)
    else $error("result shown with no request in flight");

  // pipeline holds at most its depth
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'(DEPTH))
    else $error("more requests in flight than pipeline stages");

  // an empty or draining output means the input side can take a request
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while output is free");

  // stalled result stays, unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(i_out_o) && $stable(q_out_o) && $stable(last_out_o)))
    else $error("stalled result dropped or changed");

endmodule

bind nco_complex_frequency_shifter nco_cfs_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_nco_cfs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .i_out_o    (i_out_o),
  .q_out_o    (q_out_o),
  .last_out_o (last_out_o)
);

// ===== tb/nco_complex_frequency_shifter_test.sv =====
// Testbench for nco_complex_frequency_shifter: corner-case and random I/Q requests
// under bursty input and a stalling receiver, checked against a local NCO predictor.
// Depends on nco_cfs_pkg and the shifter RTL.
module nco_complex_frequency_shifter_test;
  import nco_cfs_pkg::*;

  localparam int unsigned SW            = SAMPLE_BITS_DEF;
  localparam int unsigned PW            = PHASE_BITS_DEF;
  localparam int unsigned AW            = TABLE_ADDR_BITS_DEF;
  localparam int unsigned LUT_LEN       = 1 << AW;
  localparam int unsigned RAND_PER_STEP = 160;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned MAX_REPORTS   = 20;
  localparam longint      SAT_HI        = (longint'(1) << (SW - 1)) - 1;
  localparam longint      SAT_LO        = -SAT_HI - 1;

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quadrant_e;

  typedef struct packed {
    logic signed [SW-1:0] i_val;
    logic signed [SW-1:0] q_val;
    logic                 last;
  } iq_sample_t;

  // DUT ports
  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 phase_step_we_i = 1'b0;
  logic [STEP_BITS-1:0] phase_step_i    = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  logic signed [SW-1:0] i_in_i          = '0;
  logic signed [SW-1:0] q_in_i          = '0;
  logic                 last_sample_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  logic signed [SW-1:0] i_out_o;
  logic signed [SW-1:0] q_out_o;
  logic                 last_out_o;

  // Predictor state
  int                   sine_lut [LUT_LEN+1];
  logic [PW-1:0]        nco_phase = '0;
  logic [STEP_BITS-1:0] nco_step  = '0;

  iq_sample_t pending_q [$];
  iq_sample_t rotated_q [$];

  int unsigned sent_count    = 0;
  int unsigned checked_count = 0;
  int unsigned block_count   = 0;
  int unsigned step_count    = 0;
  int unsigned err_count     = 0;
  int unsigned idle_cycles   = 0;

  // Sender burst shaping and receiver stall pattern
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned pat_period;
  int unsigned pat_low;
  int unsigned pat_left;
  int unsigned pat_pos;

  nco_complex_frequency_shifter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .phase_step_we_i (phase_step_we_i),
    .phase_step_i    (phase_step_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .i_in_i          (i_in_i),
    .q_in_i          (q_in_i),
    .last_sample_i   (last_sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .i_out_o         (i_out_o),
    .q_out_o         (q_out_o),
    .last_out_o      (last_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Round half up by 2^15 and saturate to the sample range
  function automatic logic signed [SW-1:0] round_q15(longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end
    if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[SW-1:0];
  endfunction

  // Rotate one request by the current NCO phase, then step the phase
  function automatic iq_sample_t rotate_by_nco(iq_sample_t req);
    iq_sample_t  res;
    int unsigned k;
    longint      s;
    longint      c;
    longint      i_s;
    longint      q_s;
    k   = int'(nco_phase[PW-3 -: AW]);
    i_s = $signed(req.i_val);
    q_s = $signed(req.q_val);
    case (quadrant_e'(nco_phase[PW-1 -: 2]))
      QUAD_I: begin
        s = sine_lut[k];
        c = sine_lut[LUT_LEN - k];
      end
      QUAD_II: begin
        s = sine_lut[LUT_LEN - k];
        c = -sine_lut[k];
      end
      QUAD_III: begin
        s = -sine_lut[k];
        c = -sine_lut[LUT_LEN - k];
      end
      default: begin
        s = -sine_lut[LUT_LEN - k];
        c = sine_lut[k];
      end
    endcase
    res.i_val = round_q15(i_s * c - q_s * s);
    res.q_val = round_q15(i_s * s + q_s * c);
    res.last  = req.last;
    // the last request of a block sends the phase back to zero
    nco_phase = req.last ? '0 : nco_phase + PW'(nco_step);
    return res;
  endfunction

  // Mostly uniform levels, with the rails and zero mixed in
  function automatic logic signed [SW-1:0] random_level();
    case ($urandom_range(0, 9))
      0:       return SAT_HI[SW-1:0];
      1:       return SAT_LO[SW-1:0];
      2:       return '0;
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic iq_sample_t random_sample();
    iq_sample_t r;
    r.i_val = random_level();
    r.q_val = random_level();
    r.last  = ($urandom_range(0, 15) == 0);
    return r;
  endfunction

  task automatic queue_sample(int i_v, int q_v, bit last_v);
    iq_sample_t r;
    r.i_val = SW'(i_v);
    r.q_val = SW'(q_v);
    r.last  = last_v;
    pending_q.push_back(r);
  endtask

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  // Register write; only called with the block idle
  task automatic set_step(logic [STEP_BITS-1:0] value);
    @(posedge clk_i);
    phase_step_we_i <= 1'b1;
    phase_step_i    <= value;
    nco_step = value;
    step_count++;
    @(posedge clk_i);
    phase_step_we_i <= 1'b0;
  endtask

  // Sampled on the falling edge so that queue and valid are settled
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (pending_q.size() != 0 || in_valid_i || rotated_q.size() != 0);
  endtask

  // Driver: bursts of requests separated by random gaps
  always @(posedge clk_i) begin : drive_requests
    iq_sample_t seen_req;
    iq_sample_t next_req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        seen_req.i_val = i_in_i;
        seen_req.q_val = q_in_i;
        seen_req.last  = last_sample_i;
        rotated_q.push_back(rotate_by_nco(seen_req));
        sent_count++;
        if (last_sample_i) begin
          block_count++;
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0 || pending_q.size() == 0) begin
          if (gap_left > 0) begin
            gap_left--;
          end
          in_valid_i <= 1'b0;
        end else begin
          next_req = pending_q.pop_front();
          in_valid_i    <= 1'b1;
          i_in_i        <= next_req.i_val;
          q_in_i        <= next_req.q_val;
          last_sample_i <= next_req.last;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            // long stretch with no gaps
            burst_left = $urandom_range(64, 200);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // Monitor: checks results in order and stalls on a periodic pattern
  always @(posedge clk_i) begin : check_results
    iq_sample_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      pat_left = 0;
      pat_pos  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (rotated_q.size() == 0) begin
          report_mismatch($sformatf("result (%0d, %0d) with nothing expected",
                                    i_out_o, q_out_o));
        end else begin
          want = rotated_q.pop_front();
          if (i_out_o !== want.i_val) begin
            report_mismatch($sformatf("i_out %0d, expected %0d (result %0d)",
                                      i_out_o, $signed(want.i_val), checked_count));
          end
          if (q_out_o !== want.q_val) begin
            report_mismatch($sformatf("q_out %0d, expected %0d (result %0d)",
                                      q_out_o, $signed(want.q_val), checked_count));
          end
          if (last_out_o !== want.last) begin
            report_mismatch($sformatf("last_out %0b, expected %0b (result %0d)",
                                      last_out_o, want.last, checked_count));
          end
          checked_count++;
        end
      end
      // new stall pattern every so often; some patterns never stall
      if (pat_left == 0) begin
        pat_period = $urandom_range(2, 9);
        pat_low    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, pat_period - 1);
        pat_left   = $urandom_range(32, 256);
        pat_pos    = 0;
      end
      pat_left--;
      out_ready_i <= (pat_pos >= pat_low);
      pat_pos = (pat_pos + 1) % pat_period;
    end
  end

  // Watchdog on cycles where no request moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Timeout: nothing accepted for %0d cycles, %0d results outstanding",
               idle_cycles, rotated_q.size());
      $display("nco_complex_frequency_shifter test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    longint unsigned      ang;
    longint unsigned      ang_sq;
    longint unsigned      term;
    longint               acc;
    logic [STEP_BITS-1:0] step_plan [$];

    // quarter-wave sine, Taylor series in Q2.30 up to x^13
    for (int k = 0; k <= LUT_LEN; k++) begin
      ang    = (64'(k) * 64'd1686629713) >> AW;
      ang_sq = (ang * ang) >> 30;
      term   = ang;
      acc    = longint'(ang);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      acc = (acc + 64'sd16384) >>> 15;
      if (acc > COEF_MAX) begin
        acc = COEF_MAX;
      end
      sine_lut[k] = int'(acc);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a step of 45 degrees walks every octant, with phase wrap
    set_step(32'h2000_0000);
    queue_sample( 32767,      0, 1'b0);
    queue_sample( 32767,  32767, 1'b0);  // 45 degrees: positive saturation
    queue_sample(     0,  32767, 1'b0);
    queue_sample(-32768, -32768, 1'b0);
    queue_sample(-32768,      0, 1'b0);
    queue_sample(     0, -32768, 1'b0);
    queue_sample( 32767, -32768, 1'b0);
    queue_sample(-32768,  32767, 1'b0);
    queue_sample( 32767,  32767, 1'b0);  // wrapped back to zero phase
    queue_sample(-32768, -32768, 1'b0);  // 45 degrees: negative saturation
    queue_sample(    -1,     -1, 1'b1);  // last mark mid-cycle
    queue_sample(     1,     -1, 1'b0);  // phase back at zero
    queue_sample(    -1,      1, 1'b1);  // back-to-back last marks
    queue_sample(     0,      0, 1'b1);
    queue_sample( 32767, -32768, 1'b0);
    queue_sample(-32768, -32768, 1'b0);
    queue_sample(-21846,  12345, 1'b0);
    queue_sample( 16384, -16384, 1'b1);
    wait_drained();

    // Random: extremes of the step first, then random steps
    step_plan = {32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h4000_0000,
                 32'h0000_0001, 32'h0010_0000};
    repeat (5) step_plan.push_back($urandom);
    foreach (step_plan[p]) begin
      set_step(step_plan[p]);
      repeat (RAND_PER_STEP) pending_q.push_back(random_sample());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (rotated_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", rotated_q.size()));
    end

    $display("Rotated %0d requests under %0d phase step settings, %0d blocks closed by last",
             sent_count, step_count, block_count);
    $display("Compared %0d results, %0d mismatches", checked_count, err_count);
    if (err_count == 0) begin
      $display("nco_complex_frequency_shifter test passed");
    end else begin
      $display("nco_complex_frequency_shifter test failed");
    end
    $finish;
  end

endmodule
